// ===== rtl/core/sha256_pkg.sv =====
package sha256_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenOffset  = 56;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned Words      = 8;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [0:Words-1][31:0] SHA_IV = {
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  // source of the byte shifted into the block buffer
  typedef enum logic [1:0] {
    BSEL_DATA,
    BSEL_PAD,
    BSEL_ZERO,
    BSEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic       shift_en;
    byte_sel_t  byte_sel;
    logic [2:0] len_idx;
    logic       count_en;
    logic       load_work;
    logic       round_en;
    logic [5:0] round_idx;
    logic       chain_add;
    logic       out_load;
  } dp_cmd_t;

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned amt);
    ror32 = (v >> amt) | (v << (32 - amt));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    case (idx)
      6'd0:  round_k = 32'h428A2F98;
      6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hB5C0FBCF;
      6'd3:  round_k = 32'hE9B5DBA5;
      6'd4:  round_k = 32'h3956C25B;
      6'd5:  round_k = 32'h59F111F1;
      6'd6:  round_k = 32'h923F82A4;
      6'd7:  round_k = 32'hAB1C5ED5;
      6'd8:  round_k = 32'hD807AA98;
      6'd9:  round_k = 32'h12835B01;
      6'd10: round_k = 32'h243185BE;
      6'd11: round_k = 32'h550C7DC3;
      6'd12: round_k = 32'h72BE5D74;
      6'd13: round_k = 32'h80DEB1FE;
      6'd14: round_k = 32'h9BDC06A7;
      6'd15: round_k = 32'hC19BF174;
      6'd16: round_k = 32'hE49B69C1;
      6'd17: round_k = 32'hEFBE4786;
      6'd18: round_k = 32'h0FC19DC6;
      6'd19: round_k = 32'h240CA1CC;
      6'd20: round_k = 32'h2DE92C6F;
      6'd21: round_k = 32'h4A7484AA;
      6'd22: round_k = 32'h5CB0A9DC;
      6'd23: round_k = 32'h76F988DA;
      6'd24: round_k = 32'h983E5152;
      6'd25: round_k = 32'hA831C66D;
      6'd26: round_k = 32'hB00327C8;
      6'd27: round_k = 32'hBF597FC7;
      6'd28: round_k = 32'hC6E00BF3;
      6'd29: round_k = 32'hD5A79147;
      6'd30: round_k = 32'h06CA6351;
      6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27B70A85;
      6'd33: round_k = 32'h2E1B2138;
      6'd34: round_k = 32'h4D2C6DFC;
      6'd35: round_k = 32'h53380D13;
      6'd36: round_k = 32'h650A7354;
      6'd37: round_k = 32'h766A0ABB;
      6'd38: round_k = 32'h81C2C92E;
      6'd39: round_k = 32'h92722C85;
      6'd40: round_k = 32'hA2BFE8A1;
      6'd41: round_k = 32'hA81A664B;
      6'd42: round_k = 32'hC24B8B70;
      6'd43: round_k = 32'hC76C51A3;
      6'd44: round_k = 32'hD192E819;
      6'd45: round_k = 32'hD6990624;
      6'd46: round_k = 32'hF40E3585;
      6'd47: round_k = 32'h106AA070;
      6'd48: round_k = 32'h19A4C116;
      6'd49: round_k = 32'h1E376C08;
      6'd50: round_k = 32'h2748774C;
      6'd51: round_k = 32'h34B0BCB5;
      6'd52: round_k = 32'h391C0CB3;
      6'd53: round_k = 32'h4ED8AA4A;
      6'd54: round_k = 32'h5B9CCA4F;
      6'd55: round_k = 32'h682E6FF3;
      6'd56: round_k = 32'h748F82EE;
      6'd57: round_k = 32'h78A5636F;
      6'd58: round_k = 32'h84C87814;
      6'd59: round_k = 32'h8CC70208;
      6'd60: round_k = 32'h90BEFFFA;
      6'd61: round_k = 32'hA4506CEB;
      6'd62: round_k = 32'hBEF9A3F7;
      6'd63: round_k = 32'hC67178F2;
      default: round_k = 32'h0;
    endcase
  endfunction

endpackage

// ===== rtl/core/sha256_ctrl.sv =====
module sha256_ctrl
  import sha256_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_byte_valid,
  input  logic    in_finish,
  input  logic    out_busy,
  output logic    in_stall,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD80,
    S_PADZ,
    S_LEN,
    S_ROUND,
    S_ADD,
    S_DONE
  } state_t;

  localparam logic [5:0] LAST_FILL  = 6'(BlockBytes - 1);
  localparam logic [5:0] LEN_FILL   = 6'(LenOffset);
  localparam logic [5:0] LAST_ROUND = 6'(Rounds - 1);

  state_t     state_r, state_nxt;
  state_t     ret_r, ret_nxt;
  logic [5:0] fill_r, fill_nxt;
  logic [5:0] round_r, round_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    fill_nxt      = fill_r;
    round_nxt     = round_r;
    cmd           = '0;
    cmd.byte_sel  = BSEL_DATA;
    cmd.len_idx   = fill_r[2:0];
    cmd.round_idx = round_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_byte_valid) begin
            cmd.shift_en = 1'b1;
            cmd.count_en = 1'b1;
            if (fill_r == LAST_FILL) begin
              fill_nxt      = '0;
              cmd.load_work = 1'b1;
              state_nxt     = S_ROUND;
              ret_nxt       = in_finish ? S_PAD80 : S_IDLE;
            end else begin
              fill_nxt  = fill_r + 6'd1;
              state_nxt = in_finish ? S_PAD80 : S_IDLE;
            end
          end else if (in_finish) begin
            state_nxt = S_PAD80;
          end
        end
      end
      S_PAD80: begin
        cmd.shift_en = 1'b1;
        cmd.byte_sel = BSEL_PAD;
        if (fill_r == LAST_FILL) begin
          fill_nxt      = '0;
          cmd.load_work = 1'b1;
          state_nxt     = S_ROUND;
          ret_nxt       = S_PADZ;
        end else begin
          fill_nxt  = fill_r + 6'd1;
          state_nxt = S_PADZ;
        end
      end
      S_PADZ: begin
        if (fill_r == LEN_FILL) begin
          state_nxt = S_LEN;
        end else begin
          cmd.shift_en = 1'b1;
          cmd.byte_sel = BSEL_ZERO;
          if (fill_r == LAST_FILL) begin
            fill_nxt      = '0;
            cmd.load_work = 1'b1;
            state_nxt     = S_ROUND;
            ret_nxt       = S_PADZ;
          end else begin
            fill_nxt = fill_r + 6'd1;
          end
        end
      end
      S_LEN: begin
        cmd.shift_en = 1'b1;
        cmd.byte_sel = BSEL_LEN;
        if (fill_r == LAST_FILL) begin
          fill_nxt      = '0;
          cmd.load_work = 1'b1;
          state_nxt     = S_ROUND;
          ret_nxt       = S_DONE;
        end else begin
          fill_nxt = fill_r + 6'd1;
        end
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        round_nxt    = round_r + 6'd1;
        if (round_r == LAST_ROUND) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        cmd.chain_add = 1'b1;
        state_nxt     = ret_r;
      end
      S_DONE: begin
        // digest bank still draining the previous message
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      fill_r  <= '0;
      round_r <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      fill_r  <= fill_nxt;
      round_r <= round_nxt;
    end
  end

endmodule

// ===== rtl/core/sha256_dp.sv =====
module sha256_dp
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  input  logic [7:0]  in_data_byte,
  output logic        out_busy,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  localparam int unsigned BufBits = BlockBytes * 8;

  // block buffer, word 0 in the top bits; doubles as the message schedule window
  logic [BufBits-1:0]     buf_r, buf_nxt;
  logic [0:Words-1][31:0] chain_r, chain_nxt;
  logic [0:Words-1][31:0] work_r, work_nxt;
  logic [7:0][7:0]        bits_r, bits_nxt;
  logic [0:Words-1][31:0] bank_r, bank_nxt;
  logic [2:0]             idx_r, idx_nxt;
  logic                   busy_r, busy_nxt;

  logic [7:0]  shift_byte;
  logic [31:0] w_t, w_new, t1, t2;
  logic        out_take;

  assign w_t   = buf_r[BufBits-1 -: 32];
  assign w_new = w_t + ssig0(buf_r[BufBits-1-32 -: 32]) + buf_r[BufBits-1-9*32 -: 32]
               + ssig1(buf_r[BufBits-1-14*32 -: 32]);

  assign t1 = work_r[7] + bsig1(work_r[4])
            + ((work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]))
            + round_k(cmd.round_idx) + w_t;
  assign t2 = bsig0(work_r[0])
            + ((work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]));

  always_comb begin
    case (cmd.byte_sel)
      BSEL_DATA: shift_byte = in_data_byte;
      BSEL_PAD:  shift_byte = PAD_BYTE;
      BSEL_ZERO: shift_byte = 8'h00;
      BSEL_LEN:  shift_byte = bits_r[3'd7 - cmd.len_idx];
      default:   shift_byte = 8'h00;
    endcase
  end

  assign out_take = busy_r && !out_stall;

  always_comb begin
    buf_nxt   = buf_r;
    work_nxt  = work_r;
    chain_nxt = chain_r;
    bits_nxt  = bits_r;
    bank_nxt  = bank_r;
    idx_nxt   = idx_r;
    busy_nxt  = busy_r;

    if (cmd.shift_en) begin
      buf_nxt = {buf_r[BufBits-9:0], shift_byte};
    end else if (cmd.round_en) begin
      buf_nxt = {buf_r[BufBits-33:0], w_new};
    end

    if (cmd.count_en) begin
      bits_nxt = bits_r + 64'd8;
    end

    if (cmd.load_work) begin
      work_nxt = chain_r;
    end else if (cmd.round_en) begin
      work_nxt = {t1 + t2, work_r[0], work_r[1], work_r[2],
                  work_r[3] + t1, work_r[4], work_r[5], work_r[6]};
    end

    if (cmd.chain_add) begin
      for (int i = 0; i < Words; i++) begin
        chain_nxt[i] = chain_r[i] + work_r[i];
      end
    end

    if (cmd.out_load) begin
      bank_nxt  = chain_r;
      chain_nxt = SHA_IV;
      bits_nxt  = '0;
      idx_nxt   = '0;
      busy_nxt  = 1'b1;
    end else if (out_take) begin
      bank_nxt = {bank_r[1:Words-1], 32'h0};
      idx_nxt  = idx_r + 3'd1;
      if (idx_r == 3'(Words - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= SHA_IV;
      bits_r  <= '0;
      idx_r   <= '0;
      busy_r  <= 1'b0;
    end else begin
      chain_r <= chain_nxt;
      bits_r  <= bits_nxt;
      idx_r   <= idx_nxt;
      busy_r  <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r  <= buf_nxt;
    work_r <= work_nxt;
    bank_r <= bank_nxt;
  end

  assign out_busy        = busy_r;
  assign out_valid       = busy_r;
  assign out_digest_word = bank_r[0];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == 3'(Words - 1));

endmodule

// ===== rtl/core/sha256_byte_stream_hasher.sv =====
// Channel  | Direction | Ports                                            | Handshake
// ---------+-----------+--------------------------------------------------+--------------------
// input    | in        | in_data_byte[7:0], in_byte_valid, in_finish      | in_valid / in_stall
// result   | out       | out_digest_word[31:0], out_word_index[2:0],      | out_valid / out_stall
//          |           | out_last_word                                    |
//
// A byte item that leaves the block part-full only shifts the byte in; in_stall stays
// low for the next item. The 64th byte of a block starts a compression: 64 rounds at
// one round per cycle in the single round unit, then the chain add, with in_stall high
// until the add is done.
// A finish item pads one byte per cycle except while a block is compressed, writes the
// 8 length bytes and runs one or two compressions before the digest reaches the output bank.
// Synchronous active-low reset loads the initial hash values and clears the counts.
// in_stall is high while an item is being worked on; the 8 digest words drain from
// their own bank, so out_stall only holds up the next finish item, not byte items.
module sha256_byte_stream_hasher
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_finish,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  dp_cmd_t cmd;
  logic    out_busy;

  // sequencer: byte intake, padding, length, round count
  sha256_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_byte_valid (in_byte_valid),
    .in_finish     (in_finish),
    .out_busy      (out_busy),
    .in_stall      (in_stall),
    .cmd           (cmd)
  );

  // block buffer/schedule window, round unit, chain value, digest bank
  sha256_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_data_byte    (in_data_byte),
    .out_busy        (out_busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

endmodule
